[hdl/sfd_pkg.sv]
// Shared types, constants and CRC helpers for the sensor frame decoder.
// No dependencies; imported by every other file in hdl/.
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int SFD_QUEUE_DEPTH = 2;
	localparam int SFD_FRAME_BYTES = 6;

	localparam logic [2:0] LAST_POS_A = 3'd2;
	localparam logic [2:0] LAST_POS_B = 3'd6;

	localparam logic [7:0] CRC_A_POLY = 8'h8C;
	localparam logic [7:0] CRC_A_INIT = 8'h00;
	localparam logic [7:0] CRC_B_POLY = 8'h31;
	localparam logic [7:0] CRC_B_INIT = 8'hFF;
	localparam int         BUSY_BIT   = 7;

	localparam logic signed [16:0] TEMP_A_OFFSET = 17'sd6400;
	localparam logic signed [26:0] TEMP_B_OFFSET = 27'sd13107200;
	localparam logic [5:0]         TEMP_B_SCALE  = 6'd50;
	localparam logic [4:0]         HUM_B_SCALE   = 5'd25;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_CRC_ERR  = 2'd1,
		STATUS_BUSY     = 2'd2,
		STATUS_CRC_WARN = 2'd3
	} sfd_status_t;

	// one finished frame handed from front to back
	typedef struct packed {
		logic                              fmt_b;
		logic                              crc_match;
		logic [SFD_FRAME_BYTES-1:0][7:0]   bytes;
	} sfd_rec_t;

	function automatic logic [7:0] crc_a_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_A_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] crc_b_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_B_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

[hdl/sensor_frame_decoder.sv]
// Top level of the sensor frame decoder: front, record queue, back.
// Depends on sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
//   channel    dir  content
//   ---------  ---  --------------------------------------------------
//   s_axis     in   tdata[7:0] rx_byte; tuser[0] frame_start
//   m_axis     out  tdata[16:0] temperature_q8, [31:17] humidity_q8;
//                   tuser[1:0] frame_status
//   frame_fmt  in   frame_format_wr_en / frame_format_wr_data, 0=A 1=B
//
// One byte per cycle while the record queue is not full; the front's
// position/CRC register pair closes the only loop.
// Reset clears position, CRC, queue and output valid; format resets to A.
// s_tready drops only when the record queue is full; a stalled m_axis
// fills the output register and then the queue.
`timescale 1ns / 1ps

module sensor_frame_decoder import sfd_pkg::*; #(
	parameter int QUEUE_DEPTH = SFD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_format_wr_en,
	input  logic        frame_format_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [16:0] temperature_q8, [31:17] humidity_q8
	output logic [1:0]  m_tuser    // [1:0] frame_status
);

	logic               fmt_b_q;
	logic               push;
	sfd_rec_t           push_data;
	logic               full;
	logic               pop;
	sfd_rec_t           pop_data;
	logic               not_empty;
	logic signed [16:0] temperature_q8;
	logic [14:0]        humidity_q8;
	sfd_status_t        frame_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_b_q <= 1'b0;
		end else if (frame_format_wr_en) begin
			fmt_b_q <= frame_format_wr_data;
		end
	end

	sfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fmt_b       (fmt_b_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser[0]),
		.push        (push),
		.push_data   (push_data),
		.queue_full  (full)
	);

	sfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	sfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (not_empty),
		.rec            (pop_data),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.temperature_q8 (temperature_q8),
		.humidity_q8    (humidity_q8),
		.frame_status   (frame_status)
	);

	assign m_tdata = {humidity_q8, temperature_q8};
	assign m_tuser = frame_status;

endmodule

[hdl/sfd_front.sv]
// Front end: takes frame bytes, tracks position and running CRC, stores
// payload bytes and pushes one record per finished frame. Uses sfd_pkg.
`timescale 1ns / 1ps

module sfd_front import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fmt_b,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	output logic       push,
	output sfd_rec_t   push_data,
	input  logic       queue_full
);

	logic [2:0] pos_q;
	logic [7:0] crc_q;
	logic [SFD_FRAME_BYTES-1:0][7:0] bytes_q;

	logic [2:0] pos;
	logic [7:0] crc_base;
	logic [7:0] crc_next;
	logic       is_check;
	logic       accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pos      = frame_start ? 3'd0 : pos_q;
		crc_base = (pos == 3'd0) ? (fmt_b ? CRC_B_INIT : CRC_A_INIT) : crc_q;
		crc_next = fmt_b ? crc_b_byte(crc_base, rx_byte) : crc_a_byte(crc_base, rx_byte);
		is_check = pos >= (fmt_b ? LAST_POS_B : LAST_POS_A);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
			crc_q <= 8'h00;
		end else if (accept) begin
			if (is_check) begin
				pos_q <= 3'd0;
				crc_q <= crc_base;
			end else begin
				pos_q <= pos + 3'd1;
				crc_q <= crc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_check && (pos < 3'(SFD_FRAME_BYTES))) begin
			bytes_q[pos] <= rx_byte;
		end
	end

	assign push                = accept && is_check;
	assign push_data.fmt_b     = fmt_b;
	assign push_data.crc_match = (crc_base == rx_byte);
	assign push_data.bytes     = bytes_q;

endmodule

[hdl/sfd_queue.sv]
// Small FIFO of finished-frame records between front and back.
// Uses sfd_pkg for the record type.
`timescale 1ns / 1ps

module sfd_queue import sfd_pkg::*; #(
	parameter int DEPTH = SFD_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sfd_rec_t push_data,
	output logic     full,
	input  logic     pop,
	output sfd_rec_t pop_data,
	output logic     not_empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	sfd_rec_t        mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/sfd_back.sv]
// Back end: converts a finished-frame record to Q8 temperature, humidity
// and status, held in an output register. Uses sfd_pkg.
`timescale 1ns / 1ps

module sfd_back import sfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sfd_rec_t           rec,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] temperature_q8,
	output logic [14:0]        humidity_q8,
	output sfd_status_t        frame_status
);

	logic               valid_q;
	logic signed [16:0] temp_q;
	logic [14:0]        hum_q;
	sfd_status_t        status_q;

	logic [19:0]        raw_h;
	logic [19:0]        raw_t;
	logic [25:0]        prod_t;
	logic signed [26:0] num_t;
	logic signed [16:0] temp_b;
	logic [24:0]        prod_h;
	logic signed [16:0] temp_a;
	logic signed [16:0] temp_n;
	logic [14:0]        hum_n;
	sfd_status_t        status_n;

	always_comb begin
		raw_h  = {rec.bytes[1], rec.bytes[2], rec.bytes[3][7:4]};
		raw_t  = {rec.bytes[3][3:0], rec.bytes[4], rec.bytes[5]};
		prod_t = raw_t * TEMP_B_SCALE;
		num_t  = $signed({1'b0, prod_t}) - TEMP_B_OFFSET;
		// truncate toward zero
		temp_b = 17'(num_t >>> 10) + 17'((num_t < 0) && (num_t[9:0] != 10'd0));
		prod_h = raw_h * HUM_B_SCALE;
		temp_a = 17'($signed({rec.bytes[1], rec.bytes[0]})) + TEMP_A_OFFSET;

		temp_n   = '0;
		hum_n    = '0;
		status_n = STATUS_OK;
		if (!rec.fmt_b) begin
			if (rec.crc_match) begin
				temp_n = temp_a;
			end else begin
				status_n = STATUS_CRC_ERR;
			end
		end else if (rec.bytes[0][BUSY_BIT]) begin
			status_n = STATUS_BUSY;
		end else begin
			temp_n   = temp_b;
			hum_n    = prod_h[24:10];
			status_n = rec.crc_match ? STATUS_OK : STATUS_CRC_WARN;
		end
	end

	assign pop = in_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			temp_q   <= temp_n;
			hum_q    <= hum_n;
			status_q <= status_n;
		end
	end

	assign out_valid      = valid_q;
	assign temperature_q8 = temp_q;
	assign humidity_q8    = hum_q;
	assign frame_status   = status_q;

endmodule

[bench/testbench.sv]
// Self-checking bench for sensor_frame_decoder: drives frame bytes over the input stream,
// predicts each decoded result in a small scoreboard and checks every output beat.
// Depends on sfd_pkg and the RTL in hdl/; needs no other files.
`timescale 1ns / 1ps

module testbench;
	import sfd_pkg::*;

	localparam int RANDOM_BYTES = 850;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 20;
	localparam int CFG_SETTLE   = 10;

	typedef struct packed {
		logic signed [16:0] temp_q8;
		logic [14:0]        hum_q8;
		sfd_status_t        status;
	} frame_result_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

	class frame_scoreboard;
		bit            fmt_b;
		bit [2:0]      pos;
		bit [7:0]      run_crc;
		bit [7:0]      stored [6];
		frame_result_t expected_q[$];
		int            mismatches;
		int            n_ok, n_rejected, n_busy, n_warn;

		static function bit [7:0] crc_step(bit use_b, bit [7:0] crc, bit [7:0] b);
			bit [7:0] c;
			c = crc ^ b;
			for (int k = 0; k < 8; k++) begin
				if (use_b)
					c = c[7] ? ((c << 1) ^ CRC_B_POLY) : (c << 1);
				else
					c = c[0] ? ((c >> 1) ^ CRC_A_POLY) : (c >> 1);
			end
			return c;
		endfunction

		// one accepted byte; a check byte queues one decoded frame
		function void note_byte(bit [7:0] b, bit start);
			bit [2:0]      last_pos;
			bit [7:0]      crc;
			bit [19:0]     raw_h, raw_t;
			int            raw_a;
			longint        num;
			frame_result_t r;
			if (start)
				pos = 0;
			last_pos = fmt_b ? LAST_POS_B : LAST_POS_A;
			crc = (pos == 0) ? (fmt_b ? CRC_B_INIT : CRC_A_INIT) : run_crc;
			if (pos < last_pos) begin
				stored[pos] = b;
				run_crc = crc_step(fmt_b, crc, b);
				pos = pos + 3'd1;
				return;
			end
			pos = 0;
			run_crc = crc;
			r.temp_q8 = '0;
			r.hum_q8 = '0;
			if (!fmt_b) begin
				if (crc != b) begin
					r.status = STATUS_CRC_ERR;
				end else begin
					raw_a = int'($signed({stored[1], stored[0]}));
					r.temp_q8 = 17'(raw_a + 6400);
					r.status = STATUS_OK;
				end
			end else if (stored[0][BUSY_BIT]) begin
				r.status = STATUS_BUSY;
			end else begin
				raw_h = {stored[1], stored[2], stored[3][7:4]};
				raw_t = {stored[3][3:0], stored[4], stored[5]};
				num = longint'(raw_t) * 50 - longint'(13107200);
				r.temp_q8 = 17'(num / 1024);
				r.hum_q8 = 15'((longint'(raw_h) * 25) >>> 10);
				r.status = (crc != b) ? STATUS_CRC_WARN : STATUS_OK;
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [31:0] tdata, logic [1:0] tuser);
			frame_result_t e;
			string         bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result beat temp=%0d hum=%0d status=%0d",
						$signed(tdata[16:0]), tdata[31:17], tuser);
				return;
			end
			e = expected_q.pop_front();
			case (e.status)
				STATUS_OK:      n_ok++;
				STATUS_CRC_ERR: n_rejected++;
				STATUS_BUSY:    n_busy++;
				default:        n_warn++;
			endcase
			bad = "";
			if (tdata[16:0] !== e.temp_q8)
				bad = {bad, " temperature"};
			if (tdata[31:17] !== e.hum_q8)
				bad = {bad, " humidity"};
			if (tuser !== e.status)
				bad = {bad, " status"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("ERROR:%s mismatch: expected temp=%0d hum=%0d status=%0d,",
						bad, e.temp_q8, e.hum_q8, e.status);
					$display(" got temp=%0d hum=%0d status=%0d",
						$signed(tdata[16:0]), tdata[31:17], tuser);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        frame_format_wr_en = 1'b0;
	logic        frame_format_wr_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	frame_scoreboard sb;
	int          burst_left = 0;
	int          sent_bytes = 0;
	int          phases = 0;
	int          cycle_count = 0;
	bit          cur_fmt = 1'b0;
	rx_pattern_t rx_mode = RX_OPEN;
	int          mode_left = 0;

	sensor_frame_decoder DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.frame_format_wr_en   (frame_format_wr_en),
		.frame_format_wr_data (frame_format_wr_data),
		.s_tvalid             (s_tvalid),
		.s_tready             (s_tready),
		.s_tdata              (s_tdata),
		.s_tuser              (s_tuser),
		.m_tvalid             (m_tvalid),
		.m_tready             (m_tready),
		.m_tdata              (m_tdata),
		.m_tuser              (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stall pattern, switched to a new random pattern when mode_left runs out
	always @(posedge clk) begin
		if (mode_left == 0) begin
			rx_mode = rx_pattern_t'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 300);
		end
		mode_left--;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= (mode_left % 6 == 0);
			default:   m_tready <= (mode_left % 7) < 3;
		endcase
	end

	// outputs are stable at the falling edge; a beat seen here is taken at the next rise
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	task automatic send_byte(input logic [7:0] b, input logic start);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		sb.note_byte(b, start);
		sent_bytes++;
		@(posedge clk);
	endtask

	task automatic set_format(input bit fmt);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		frame_format_wr_en <= 1'b1;
		frame_format_wr_data <= fmt;
		@(posedge clk);
		frame_format_wr_en <= 1'b0;
		sb.fmt_b = fmt;
		cur_fmt = fmt;
	endtask

	// body holds the data bytes, first byte lowest; count cuts the frame short
	task automatic send_frame(input logic [47:0] body, input bit good_crc, input bit start,
			input int count);
		int         len;
		logic [7:0] crc, chk;
		len = cur_fmt ? 7 : 3;
		crc = cur_fmt ? CRC_B_INIT : CRC_A_INIT;
		for (int k = 0; k < len - 1; k++)
			crc = frame_scoreboard::crc_step(cur_fmt, crc, body[8*k +: 8]);
		chk = good_crc ? crc : crc ^ 8'($urandom_range(1, 255));
		for (int k = 0; k < count && k < len; k++)
			send_byte((k < len - 1) ? body[8*k +: 8] : chk, (k == 0) ? start : 1'b0);
	endtask

	function automatic logic [47:0] random_body();
		logic [47:0] v;
		v = {16'($urandom), 32'($urandom)};
		if (cur_fmt) begin
			v[BUSY_BIT] = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				v[47:8] = ($urandom_range(0, 1) == 1) ? '1 : '0;
		end else if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0:       v[15:0] = 16'h7FFF;
				1:       v[15:0] = 16'h8000;
				2:       v[15:0] = 16'hFFFF;
				default: v[15:0] = 16'h0000;
			endcase
		end
		return v;
	endfunction

	initial begin
		int target;
		int phase_end;
		int pick;
		int len;
		bit first;
		sb = new;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: temperature extremes, rollover without start, rejects and warnings
		set_format(1'b0);
		send_frame(48'h8000, 1'b1, 1'b1, 3);
		send_frame(48'h7FFF, 1'b1, 1'b0, 3);
		send_frame(48'h1234, 1'b0, 1'b1, 3);
		set_format(1'b1);
		send_frame(48'h0, 1'b1, 1'b1, 7);
		send_frame({40'hFF_FFFF_FFFF, 8'h7F}, 1'b0, 1'b1, 7);

		target = sent_bytes + RANDOM_BYTES;
		while (sent_bytes < target) begin
			set_format(($urandom_range(0, 3) == 0) ? cur_fmt : !cur_fmt);
			phases++;
			first = 1'b1;
			len = cur_fmt ? 7 : 3;
			phase_end = sent_bytes + $urandom_range(60, 160);
			while (sent_bytes < phase_end && sent_bytes < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 78)
					send_frame(random_body(), $urandom_range(0, 4) != 0,
						first ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0), len);
				else if (pick < 88)
					send_frame(random_body(), 1'b1, 1'b1, $urandom_range(1, len - 1));
				else
					repeat ($urandom_range(1, 4))
						send_byte(8'($urandom), $urandom_range(0, 2) == 0);
				first = 1'b0;
			end
			// leave a frame open so the next format change lands mid-frame
			if ($urandom_range(0, 9) < 4)
				send_frame(random_body(), 1'b1, 1'b1, $urandom_range(1, len - 1));
		end

		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes over %0d format phases plus the directed frames.",
			sent_bytes, phases);
		$write("Decoded %0d good frames, %0d CRC rejects, %0d busy, ",
			sb.n_ok, sb.n_rejected, sb.n_busy);
		$display("%0d CRC warnings; %0d mismatches.", sb.n_warn, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
